// ===== design/ksd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

   // scan code set 1 constants
   localparam logic [7:0] PREFIX_BYTE = 8'hE0;
   localparam logic [7:0] EXT_UP      = 8'h48;
   localparam logic [7:0] EXT_DOWN    = 8'h50;
   localparam logic [6:0] LSHIFT_CODE = 7'h2A;
   localparam logic [6:0] RSHIFT_CODE = 7'h36;
   localparam int         TABLE_LEN   = 59;

   typedef enum logic [1:0] {
      KEY_CHAR = 2'd0,
      KEY_UP   = 2'd1,
      KEY_DN   = 2'd2
   } key_class_type;

   // result of decoding one scan byte against the current flags
   typedef struct packed {
      logic          emit;
      key_class_type key_class;
      logic [6:0]    char_code;
      logic          shift_next;
      logic          prefix_next;
   } decode_type;

   localparam logic [6:0] PLAIN_TAB [0:TABLE_LEN-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h2D, 7'h3D, 7'h08, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
      7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
   };

   localparam logic [6:0] UPPER_TAB [0:TABLE_LEN-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h5F, 7'h2B, 7'h08, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
      7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
   };

   function automatic decode_type decode(input logic [7:0] scan, input logic shift,
                                         input logic prefix);
      decode_type d;
      logic [5:0] idx;
      logic [6:0] ch;
      logic       in_table;
      d.emit        = 1'b0;
      d.key_class   = KEY_CHAR;
      d.char_code   = 7'd0;
      d.shift_next  = shift;
      d.prefix_next = 1'b0;
      in_table      = (scan < 8'(TABLE_LEN));
      idx           = in_table ? scan[5:0] : 6'd0;
      ch            = shift ? UPPER_TAB[idx] : PLAIN_TAB[idx];
      if (prefix) begin
         // byte after the prefix is always an extended key
         if (scan == EXT_UP) begin
            d.emit      = 1'b1;
            d.key_class = KEY_UP;
         end else if (scan == EXT_DOWN) begin
            d.emit      = 1'b1;
            d.key_class = KEY_DN;
         end
      end else if (scan == PREFIX_BYTE) begin
         d.prefix_next = 1'b1;
      end else if (scan[7]) begin
         // break code, releases shift for either shift key
         if (scan[6:0] == LSHIFT_CODE || scan[6:0] == RSHIFT_CODE) begin
            d.shift_next = 1'b0;
         end
      end else if (scan[6:0] == LSHIFT_CODE || scan[6:0] == RSHIFT_CODE) begin
         d.shift_next = 1'b1;
      end else if (in_table && ch != 7'd0) begin
         d.emit      = 1'b1;
         d.char_code = ch;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== design/keyboard_scancode_decoder_core.sv =====
// path: an accepted request is captured in the input register, decoded, and written to
//    the response register; rsp_valid rises when the held byte retires, which rsp_stall can hold back
// throughput: one scan byte per cycle while rsp_stall does not hold back a response, set
//    by the single decode stage between the input register and the response register
// reset: synchronous, active high; clears both valid flags, the shift flag and the
//    extended prefix flag
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_scan_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_key_class,
   output logic [6:0]      rsp_char_code
);

   logic                   in_valid_ff;
   logic [7:0]             in_scan_ff;
   logic                   shift_ff, shift_in;
   logic                   prefix_ff, prefix_in;
   logic                   rsp_valid_ff;
   ksd_pkg::key_class_type rsp_class_ff;
   logic [6:0]             rsp_char_ff;
   ksd_pkg::decode_type    dec;
   logic                   in_move;

   // decode the held byte against the current flags
   always_comb begin
      dec = ksd_pkg::decode(in_scan_ff, shift_ff, prefix_ff);
   end

   // held byte retires when it has no response or the response register is free
   assign in_move   = in_valid_ff && (!dec.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !in_move;
   assign shift_in  = in_move ? dec.shift_next : shift_ff;
   assign prefix_in = in_move ? dec.prefix_next : prefix_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (in_move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_scan_ff <= req_scan_byte;
      end
   end

   // decoder flags
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= 1'b0;
         prefix_ff <= 1'b0;
      end else begin
         shift_ff  <= shift_in;
         prefix_ff <= prefix_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_move && dec.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move && dec.emit) begin
         rsp_class_ff <= dec.key_class;
         rsp_char_ff  <= dec.char_code;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_class = rsp_class_ff;
   assign rsp_char_code = rsp_char_ff;

`ifndef SYNTHESIS
   // arrow responses carry no character
   a_arrow_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff != ksd_pkg::KEY_CHAR |-> rsp_char_ff == 7'd0)
      else $error("arrow response with nonzero character");

   // character responses never carry a table hole
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff == ksd_pkg::KEY_CHAR |-> rsp_char_ff != 7'd0)
      else $error("character response with zero code");

   // a prefix byte retired outside a prefix arms the prefix flag
   a_prefix_arm: assert property (@(posedge clock) disable iff (reset)
      in_move && !prefix_ff && in_scan_ff == ksd_pkg::PREFIX_BYTE |=> prefix_ff)
      else $error("prefix byte did not arm the prefix flag");

   // the prefix flag lasts for exactly one retired byte
   a_prefix_once: assert property (@(posedge clock) disable iff (reset)
      in_move && prefix_ff |=> !prefix_ff)
      else $error("prefix flag survived the following byte");

   // stall only while a byte is held that cannot retire
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && dec.emit && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked transaction");
`endif

endmodule

`default_nettype wire
